### rtl/txc_pkg.sv
`default_nettype none

package txc_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths of the request and response words, and the width of a stored cell.
    localparam int REQ_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = 11;
    localparam int STORE_W = ATTR_W + CHAR_W;

    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'd32;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_PRINT,
        OP_SCROLL,
        OP_CLEAR,
        OP_READ
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_PRINT
    } t_state;

    typedef struct packed {
        logic take;
        logic exec_now;
        logic copy_step;
        logic fill_step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        t_op  in_op;
        t_op  held_op;
        logic out_free;
        logic copy_last;
        logic fill_last;
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/txc_req_if.sv
`default_nettype none

interface txc_req_if import txc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_code;
    logic [ATTR_W-1:0] attribute;
    logic [CELL_W-1:0] cell_index;

    modport source (output valid, output req_type, output char_code, output attribute,
                    output cell_index, input ready);
    modport sink   (input valid, input req_type, input char_code, input attribute,
                    input cell_index, output ready);
endinterface

`default_nettype wire

### rtl/txc_rsp_if.sv
`default_nettype none

interface txc_rsp_if import txc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] cursor_pos;
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_attr;
    logic              scrolled;

    modport source (output valid, output cursor_pos, output read_char, output read_attr,
                    output scrolled, input ready);
    modport sink   (input valid, input cursor_pos, input read_char, input read_attr,
                    input scrolled, output ready);
endinterface

`default_nettype wire

### rtl/txc_datapath.sv
`default_nettype none

module txc_datapath import txc_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    input  wire [REQ_W-1:0]   i_req_type,
    input  wire [CHAR_W-1:0]  i_char_code,
    input  wire [ATTR_W-1:0]  i_attribute,
    input  wire [CELL_W-1:0]  i_cell_index,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output logic [CELL_W-1:0] o_cursor_pos,
    output logic [CHAR_W-1:0] o_read_char,
    output logic [ATTR_W-1:0] o_read_attr,
    output logic              o_scrolled
);

    localparam int TOTAL = COLUMNS * ROWS;
    localparam int AW    = $clog2(TOTAL + 1);
    localparam int IW    = $clog2(TOTAL);
    localparam int CLW   = $clog2(COLUMNS);
    localparam int CW    = (AW > CELL_W) ? AW : CELL_W;

    logic [STORE_W-1:0] r_cells [TOTAL];
    logic [STORE_W-1:0] r_rdata;

    logic [AW-1:0]     r_cursor, n_cursor;
    logic [CLW-1:0]    r_col, n_col;
    logic [AW-1:0]     r_sweep;
    logic [ATTR_W-1:0] r_attr;
    logic [CHAR_W-1:0] r_char;
    t_op               r_op;
    logic              r_idx_ok;

    logic              r_out_valid;
    logic [CELL_W-1:0] r_out_cursor;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic [ATTR_W-1:0] r_out_attr, n_out_attr;
    logic              r_out_scrolled, n_out_scrolled;
    logic              w_load_out;

    t_op                w_in_op;
    logic               w_at_end;
    logic               w_cur_zero;
    logic [AW-1:0]      w_cur_dec;
    logic [AW-1:0]      w_sweep_dec;
    logic [AW-1:0]      w_src;
    logic [AW:0]        w_nl_sum;
    logic [CLW-1:0]     w_col_inc, w_col_dec;
    logic               w_we;
    logic [IW-1:0]      w_waddr;
    logic [STORE_W-1:0] w_wdata;
    logic [IW-1:0]      w_raddr;

    assign w_at_end    = (r_cursor == AW'(TOTAL));
    assign w_cur_zero  = (r_cursor == '0);
    assign w_cur_dec   = r_cursor - 1'b1;
    assign w_sweep_dec = r_sweep - 1'b1;
    assign w_src       = r_sweep + AW'(COLUMNS);
    // Start of the next row is the start of this row plus one row.
    assign w_nl_sum    = {1'b0, r_cursor} - (AW+1)'(r_col) + (AW+1)'(COLUMNS);
    assign w_col_inc   = (r_col == CLW'(COLUMNS - 1)) ? '0 : r_col + 1'b1;
    assign w_col_dec   = (r_col == '0) ? CLW'(COLUMNS - 1) : r_col - 1'b1;

    always_comb begin
        unique case (i_req_type)
            REQ_PUT: begin
                if (i_char_code == CHAR_NEWLINE) begin
                    w_in_op = OP_NEWLINE;
                end else if (i_char_code == CHAR_BACKSPACE) begin
                    w_in_op = OP_BACKSPACE;
                end else if (w_at_end) begin
                    w_in_op = OP_SCROLL;
                end else begin
                    w_in_op = OP_PRINT;
                end
            end
            REQ_CLEAR: w_in_op = OP_CLEAR;
            REQ_READ:  w_in_op = OP_READ;
            default:   w_in_op = OP_NONE;
        endcase
    end

    assign o_status.in_op     = w_in_op;
    assign o_status.held_op   = r_op;
    assign o_status.out_free  = !r_out_valid || i_out_ready;
    assign o_status.copy_last = (r_sweep == AW'(TOTAL - COLUMNS));
    assign o_status.fill_last = (r_sweep == AW'(TOTAL - 1));

    // Single write port; the controller never asks for two writes at once.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cursor[IW-1:0];
        w_wdata = {i_attribute, i_char_code};
        if (i_cmd.exec_now) begin
            if (w_in_op == OP_PRINT) begin
                w_we = 1'b1;
            end else if (w_in_op == OP_BACKSPACE && !w_cur_zero) begin
                w_we    = 1'b1;
                w_waddr = w_cur_dec[IW-1:0];
                w_wdata = {i_attribute, CHAR_BLANK};
            end
        end else if (i_cmd.copy_step) begin
            // The copy writes the word of the row below that was read in the cycle before.
            w_we    = (r_sweep != '0);
            w_waddr = w_sweep_dec[IW-1:0];
            w_wdata = r_rdata;
        end else if (i_cmd.fill_step) begin
            w_we    = 1'b1;
            w_waddr = r_sweep[IW-1:0];
            w_wdata = {r_attr, {CHAR_W{1'b0}}};
        end else if (i_cmd.finish && r_op == OP_SCROLL) begin
            w_we    = 1'b1;
            w_waddr = IW'(TOTAL - COLUMNS);
            w_wdata = {r_attr, r_char};
        end
    end

    assign w_raddr = i_cmd.copy_step ? w_src[IW-1:0] : IW'(i_cell_index);

    always_comb begin
        n_cursor       = r_cursor;
        n_col          = r_col;
        n_out_char     = '0;
        n_out_attr     = '0;
        n_out_scrolled = 1'b0;
        w_load_out     = 1'b0;
        if (i_cmd.exec_now) begin
            w_load_out = 1'b1;
            unique case (w_in_op)
                OP_NEWLINE: begin
                    n_cursor = (w_nl_sum > (AW+1)'(TOTAL)) ? AW'(TOTAL) : w_nl_sum[AW-1:0];
                    n_col    = '0;
                end
                OP_BACKSPACE: begin
                    if (!w_cur_zero) begin
                        n_cursor = w_cur_dec;
                        n_col    = w_col_dec;
                    end
                end
                OP_PRINT: begin
                    n_cursor = r_cursor + 1'b1;
                    n_col    = w_col_inc;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.finish) begin
            w_load_out = 1'b1;
            unique case (r_op)
                OP_SCROLL: begin
                    n_cursor       = AW'(TOTAL - COLUMNS + 1);
                    n_col          = CLW'(1);
                    n_out_scrolled = 1'b1;
                end
                OP_CLEAR: begin
                    n_cursor = '0;
                    n_col    = '0;
                end
                OP_READ: begin
                    if (r_idx_ok) begin
                        n_out_char = r_rdata[CHAR_W-1:0];
                        n_out_attr = r_rdata[STORE_W-1:CHAR_W];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cells[w_waddr] <= w_wdata;
        end
        r_rdata <= r_cells[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_col       <= '0;
            r_sweep     <= '0;
            r_attr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cursor <= n_cursor;
            r_col    <= n_col;
            if (i_cmd.take) begin
                r_sweep <= '0;
                r_attr  <= i_attribute;
            end else if (i_cmd.fill_step) begin
                r_sweep <= r_sweep + 1'b1;
            end else if (i_cmd.copy_step && !o_status.copy_last) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_char   <= i_char_code;
            r_op     <= w_in_op;
            r_idx_ok <= (CW'(i_cell_index) < CW'(TOTAL));
        end
        if (w_load_out) begin
            r_out_cursor   <= CELL_W'(n_cursor);
            r_out_char     <= n_out_char;
            r_out_attr     <= n_out_attr;
            r_out_scrolled <= n_out_scrolled;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_pos = r_out_cursor;
    assign o_read_char  = r_out_char;
    assign o_read_attr  = r_out_attr;
    assign o_scrolled   = r_out_scrolled;

endmodule

`default_nettype wire

### rtl/txc_controller.sv
`default_nettype none

module txc_controller import txc_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_INIT: begin
                // Clearing pass over the store after reset, attribute zero.
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = i_status.out_free;
                if (i_in_valid && i_status.out_free) begin
                    o_cmd.take = 1'b1;
                    unique case (i_status.in_op)
                        OP_READ:   n_state = ST_READ;
                        OP_SCROLL: n_state = ST_SCROLL;
                        OP_CLEAR:  n_state = ST_FILL;
                        default:   o_cmd.exec_now = 1'b1;
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            ST_SCROLL: begin
                o_cmd.copy_step = 1'b1;
                if (i_status.copy_last) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_status.fill_last) begin
                    if (i_status.held_op == OP_SCROLL) begin
                        n_state = ST_PRINT;
                    end else begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end
            end
            ST_PRINT: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/text_console_writer_top.sv
`default_nettype none

// Text console writer: a COLUMNS x ROWS store of character and attribute
// cells with a write cursor.
// Requests arrive on i_req (put character, clear screen, read cell) and each
// request returns exactly one response word on o_rsp with the cursor after
// the request, the read cell (reads only) and a scroll flag.
// Printed characters, newline, backspace and unknown types are executed as
// they are accepted and their response word is registered; a read goes
// through the registered read port of the cell store and then the response
// register. A clear sweeps the store one cell a cycle. A printed character
// at the end of the screen scrolls first: the row copy and bottom row fill
// go one cell at a time through the single write port of the store, then
// the character is written and the response is registered.
// Requests are handled one at a time; the next one is taken in the cycle its
// predecessor's response is taken, or at once if the response was delivered.
// After reset the block clears the whole store and holds i_req.ready low
// during that pass.
// When the receiver stalls, the response register holds its word and no new
// request is accepted until it is taken.

module text_console_writer_top import txc_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    txc_req_if.sink   i_req,
    txc_rsp_if.source o_rsp
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    assign i_req.ready = w_in_ready;

    txc_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    txc_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_req_type   (i_req.req_type),
        .i_char_code  (i_req.char_code),
        .i_attribute  (i_req.attribute),
        .i_cell_index (i_req.cell_index),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_cursor_pos (o_rsp.cursor_pos),
        .o_read_char  (o_rsp.read_char),
        .o_read_attr  (o_rsp.read_attr),
        .o_scrolled   (o_rsp.scrolled)
    );

endmodule

`default_nettype wire

### rtl/txc_checker.sv
`default_nettype none

module txc_checker import txc_pkg::*; #(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_valid,
    input wire              i_in_ready,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire [CELL_W-1:0] i_cursor_pos,
    input wire [CHAR_W-1:0] i_read_char,
    input wire [ATTR_W-1:0] i_read_attr,
    input wire              i_scrolled
);

    localparam int CELLS = COLUMNS * ROWS;

    // A stalled response word holds until it is taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_cursor_pos)
            && $stable(i_read_char) && $stable(i_read_attr) && $stable(i_scrolled)))
        else $error("stalled response word changed");

    // The clearing pass after reset keeps requests out.
    assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("request ready right after reset");

    // One request at a time: nothing is taken while a response is stuck.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !(i_in_valid && i_in_ready))
        else $error("request accepted while response stalled");

    // A scroll always leaves the cursor just after the first cell of the last row.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_scrolled) |->
            (i_cursor_pos == CELL_W'(CELLS - COLUMNS + 1) && i_read_char == '0
             && i_read_attr == '0))
        else $error("scroll response with wrong cursor or read data");

endmodule

bind text_console_writer_top txc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_txc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_cursor_pos (o_rsp.cursor_pos),
    .i_read_char  (o_rsp.read_char),
    .i_read_attr  (o_rsp.read_attr),
    .i_scrolled   (o_rsp.scrolled)
);

`default_nettype wire

### dv/tb_text_console_writer_top.sv
`timescale 1ns / 100ps

module tb_text_console_writer_top;
    import txc_pkg::*;

    localparam int COLUMNS     = COLUMNS_DEF;
    localparam int ROWS        = ROWS_DEF;
    localparam int TOTAL_CELLS = COLUMNS * ROWS;

    // Request type 3 has no meaning; the block must answer it without any effect.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int PHASE_ITEMS   = 483;
    localparam int SCROLL_BUDGET = 40;
    localparam int CLEAR_BUDGET  = 8;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic [REQ_W-1:0]  rtype;
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        logic [CELL_W-1:0] idx;
    } t_console_req;

    typedef struct packed {
        logic [CELL_W-1:0] cursor;
        logic [CHAR_W-1:0] rchar;
        logic [ATTR_W-1:0] rattr;
        logic              scrolled;
    } t_console_rsp;

    logic i_clk;
    logic i_rst_n;

    txc_req_if req_if();
    txc_rsp_if rsp_if();

    text_console_writer_top #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // Predicted screen contents and cursor, updated as each word is accepted.
    logic [STORE_W-1:0] screen_cells [TOTAL_CELLS];
    int unsigned        screen_cursor;
    t_console_rsp       awaited_rsps [$];

    // Requests waiting for the driver, and the cursor they will leave behind.
    t_console_req pending_reqs [$];
    t_console_req drive_req;
    t_console_rsp seen_rsp;
    int unsigned  plan_cursor;
    int unsigned  plan_scrolls;
    int unsigned  plan_clears;
    int unsigned  planned_reqs;

    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;

    int unsigned mismatch_count;
    int unsigned accepted_reqs;
    int unsigned checked_rsps;
    int unsigned seen_scrolls;
    int unsigned cleared_screens;
    int unsigned read_reqs;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #12_000_000;
        $display("%0t: timeout, %0d responses still awaited", $time, awaited_rsps.size());
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [CHAR_W-1:0] rand_byte();
        return CHAR_W'($urandom);
    endfunction

    function automatic logic [CELL_W-1:0] rand_cell();
        return CELL_W'($urandom);
    endfunction

    // Cursor after a request; scroll is set when a printed byte finds the
    // cursor past the last row.
    function automatic int unsigned next_cursor(input int unsigned cur,
                                                input logic [REQ_W-1:0] rtype,
                                                input logic [CHAR_W-1:0] ch,
                                                output bit scroll);
        int unsigned row_start;
        scroll = 1'b0;
        if (rtype == REQ_CLEAR) return 0;
        if (rtype != REQ_PUT) return cur;
        if (ch == CHAR_NEWLINE) begin
            row_start = (cur / COLUMNS + 1) * COLUMNS;
            return (row_start > TOTAL_CELLS) ? TOTAL_CELLS : row_start;
        end
        if (ch == CHAR_BACKSPACE) return (cur > 0) ? cur - 1 : 0;
        if (cur >= TOTAL_CELLS) begin
            scroll = 1'b1;
            return TOTAL_CELLS - COLUMNS + 1;
        end
        return cur + 1;
    endfunction

    task automatic predict_request(input logic [REQ_W-1:0] rtype, input logic [CHAR_W-1:0] ch,
                                   input logic [ATTR_W-1:0] attr,
                                   input logic [CELL_W-1:0] idx);
        t_console_rsp want;
        bit           scroll;
        int unsigned  nxt;
        want = '0;
        nxt = next_cursor(screen_cursor, rtype, ch, scroll);
        if (rtype == REQ_PUT && ch == CHAR_BACKSPACE) begin
            if (nxt != screen_cursor) screen_cells[nxt] = {attr, CHAR_BLANK};
        end else if (rtype == REQ_PUT && ch != CHAR_NEWLINE) begin
            if (scroll) begin
                for (int i = 0; i < TOTAL_CELLS - COLUMNS; i++)
                    screen_cells[i] = screen_cells[i + COLUMNS];
                for (int i = TOTAL_CELLS - COLUMNS; i < TOTAL_CELLS; i++)
                    screen_cells[i] = {attr, {CHAR_W{1'b0}}};
            end
            screen_cells[nxt - 1] = {attr, ch};
        end else if (rtype == REQ_CLEAR) begin
            for (int i = 0; i < TOTAL_CELLS; i++) screen_cells[i] = {attr, {CHAR_W{1'b0}}};
            cleared_screens++;
        end else if (rtype == REQ_READ) begin
            read_reqs++;
            if (idx < TOTAL_CELLS) {want.rattr, want.rchar} = screen_cells[idx];
        end
        screen_cursor = nxt;
        want.cursor   = CELL_W'(nxt);
        want.scrolled = scroll;
        awaited_rsps.push_back(want);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Scrolls and clears take a full pass over the store, so each phase has a
    // budget for them; past it, a scrolling print becomes a backspace and a
    // clear becomes a read.
    task automatic queue_request(input logic [REQ_W-1:0] rtype, input logic [CHAR_W-1:0] ch,
                                 input logic [ATTR_W-1:0] attr,
                                 input logic [CELL_W-1:0] idx);
        t_console_req item;
        bit           scroll;
        int unsigned  nxt;
        item = '{rtype: rtype, ch: ch, attr: attr, idx: idx};
        nxt = next_cursor(plan_cursor, item.rtype, item.ch, scroll);
        if (scroll && plan_scrolls >= SCROLL_BUDGET) begin
            item.ch = CHAR_BACKSPACE;
            nxt = next_cursor(plan_cursor, item.rtype, item.ch, scroll);
        end
        if (item.rtype == REQ_CLEAR && plan_clears >= CLEAR_BUDGET) begin
            item.rtype = REQ_READ;
            nxt = plan_cursor;
        end
        if (scroll) plan_scrolls++;
        if (item.rtype == REQ_CLEAR) plan_clears++;
        plan_cursor = nxt;
        planned_reqs++;
        pending_reqs.push_back(item);
    endtask

    // Mostly cells just behind the cursor, where the recent writes are.
    function automatic logic [CELL_W-1:0] read_target();
        int unsigned pick;
        int unsigned back;
        pick = $urandom_range(99);
        back = $urandom_range(159);
        if (pick < 60 && plan_cursor > 0)
            return CELL_W'((plan_cursor - 1 > back) ? plan_cursor - 1 - back : 0);
        if (pick < 90) return CELL_W'($urandom_range(TOTAL_CELLS - 1));
        return CELL_W'($urandom_range(2 ** CELL_W - 1, TOTAL_CELLS));
    endfunction

    task automatic queue_text_line();
        int unsigned       len;
        logic [ATTR_W-1:0] line_attr;
        logic [CHAR_W-1:0] ch;
        len       = $urandom_range(24, 1);
        line_attr = rand_byte();
        repeat (len) begin
            ch = rand_byte();
            while (ch == CHAR_NEWLINE || ch == CHAR_BACKSPACE) ch = rand_byte();
            queue_request(REQ_PUT, ch, ($urandom_range(3) == 0) ? rand_byte() : line_attr,
                          rand_cell());
        end
        if ($urandom_range(99) < 60)
            queue_request(REQ_PUT, CHAR_NEWLINE, rand_byte(), rand_cell());
    endtask

    task automatic wait_quiet();
        while (pending_reqs.size() != 0 || req_if.valid || awaited_rsps.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int unsigned sender_pct, input int unsigned receiver_pct);
        int unsigned phase_end;
        int unsigned kind;
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
        plan_scrolls       = 0;
        plan_clears        = 0;
        phase_end          = planned_reqs + PHASE_ITEMS;
        // Run the cursor off the bottom so that every phase saturates and scrolls.
        repeat (ROWS + 1) queue_request(REQ_PUT, CHAR_NEWLINE, rand_byte(), rand_cell());
        queue_text_line();
        repeat (4) queue_request(REQ_READ, rand_byte(), rand_byte(), read_target());
        while (planned_reqs < phase_end) begin
            kind = $urandom_range(99);
            if (kind < 40) begin
                queue_text_line();
            end else if (kind < 55) begin
                repeat ($urandom_range(6, 1))
                    queue_request(REQ_PUT, CHAR_NEWLINE, rand_byte(), rand_cell());
            end else if (kind < 65) begin
                repeat ($urandom_range(4, 1))
                    queue_request(REQ_PUT, CHAR_BACKSPACE, rand_byte(), rand_cell());
            end else if (kind < 85) begin
                repeat ($urandom_range(4, 1))
                    queue_request(REQ_READ, rand_byte(), rand_byte(), read_target());
            end else if (kind < 87) begin
                queue_request(REQ_CLEAR, rand_byte(), rand_byte(), rand_cell());
            end else begin
                repeat ($urandom_range(3, 1))
                    queue_request(REQ_W'($urandom_range(3)), rand_byte(), rand_byte(),
                                  rand_cell());
            end
        end
        wait_quiet();
    endtask

    // Driver: offers the next pending word when the channel is free, unless it idles at random (sender_idle_pct).
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                accepted_reqs++;
                predict_request(req_if.req_type, req_if.char_code, req_if.attribute,
                                req_if.cell_index);
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    drive_req = pending_reqs.pop_front();
                    req_if.req_type   <= drive_req.rtype;
                    req_if.char_code  <= drive_req.ch;
                    req_if.attribute  <= drive_req.attr;
                    req_if.cell_index <= drive_req.idx;
                    req_if.valid      <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each taken response word against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (awaited_rsps.size() == 0) begin
                    $display("%0t: unexpected response, cursor %0d char %0d attr %0d scroll %0d",
                             $time, rsp_if.cursor_pos, rsp_if.read_char, rsp_if.read_attr,
                             rsp_if.scrolled);
                    mismatch_count++;
                end else begin
                    seen_rsp = awaited_rsps.pop_front();
                    compare_field("cursor_pos", seen_rsp.cursor, rsp_if.cursor_pos);
                    compare_field("read_char", seen_rsp.rchar, rsp_if.read_char);
                    compare_field("read_attr", seen_rsp.rattr, rsp_if.read_attr);
                    compare_field("scrolled", seen_rsp.scrolled, rsp_if.scrolled);
                    checked_rsps++;
                    if (rsp_if.scrolled) seen_scrolls++;
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_PUT;
        req_if.char_code  = '0;
        req_if.attribute  = '0;
        req_if.cell_index = '0;
        rsp_if.ready      = 1'b0;
        for (int i = 0; i < TOTAL_CELLS; i++) screen_cells[i] = '0;
        screen_cursor      = 0;
        plan_cursor        = 0;
        plan_scrolls       = 0;
        plan_clears        = 0;
        planned_reqs       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mismatch_count     = 0;
        accepted_reqs      = 0;
        checked_rsps       = 0;
        seen_scrolls       = 0;
        cleared_screens    = 0;
        read_reqs          = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reads of the freshly cleared store, out-of-range reads,
        // backspace on the home cell, extreme bytes, newline, unknown type, clear.
        queue_request(REQ_READ, 8'h00, 8'h00, 11'd0);
        queue_request(REQ_READ, 8'h00, 8'h00, CELL_W'(TOTAL_CELLS - 1));
        queue_request(REQ_READ, 8'h00, 8'h00, CELL_W'(TOTAL_CELLS));
        queue_request(REQ_READ, 8'hFF, 8'hFF, 11'h7FF);
        queue_request(REQ_PUT, CHAR_BACKSPACE, 8'hFF, 11'd0);
        queue_request(REQ_PUT, 8'h00, 8'hFF, 11'h7FF);
        queue_request(REQ_PUT, 8'hFF, 8'h00, 11'd0);
        queue_request(REQ_PUT, 8'h41, 8'h1E, 11'd5);
        queue_request(REQ_PUT, CHAR_BACKSPACE, 8'h5A, 11'd0);
        queue_request(REQ_READ, 8'h00, 8'h00, 11'd0);
        queue_request(REQ_READ, 8'h00, 8'h00, 11'd1);
        queue_request(REQ_READ, 8'h00, 8'h00, 11'd2);
        queue_request(REQ_PUT, CHAR_NEWLINE, 8'h33, 11'd0);
        queue_request(REQ_PUT, 8'h7F, 8'h80, 11'd0);
        queue_request(REQ_UNUSED, 8'hFF, 8'hFF, 11'h7FF);
        queue_request(REQ_READ, 8'h00, 8'h00, CELL_W'(COLUMNS));
        queue_request(REQ_CLEAR, 8'hFF, 8'hA5, 11'd0);
        queue_request(REQ_READ, 8'h00, 8'h00, 11'd0);
        queue_request(REQ_READ, 8'h00, 8'h00, CELL_W'(TOTAL_CELLS - 1));
        queue_request(REQ_PUT, CHAR_NEWLINE, 8'h00, 11'd0);
        queue_request(REQ_PUT, CHAR_BACKSPACE, 8'hC3, 11'd0);
        queue_request(REQ_READ, 8'h00, 8'h00, CELL_W'(COLUMNS - 1));
        wait_quiet();

        run_phase(0, 0);
        run_phase(45, 0);
        run_phase(0, 45);
        run_phase(10, 10);

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Checked %0d responses to %0d requests: %0d reads, %0d clears, %0d scrolls.",
                 checked_rsps, accepted_reqs, read_reqs, cleared_screens, seen_scrolls);
        $display("Mismatches: %0d, responses still awaited: %0d.",
                 mismatch_count, awaited_rsps.size());
        if (mismatch_count == 0 && awaited_rsps.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
